// ===== hdl/bpmo_pkg.sv =====
// Shared types and constants for the byte pattern offset matcher.
`default_nettype none
package bpmo_pkg;

  // Longest pattern held by the cell row, and file offset width
  localparam int MAX_PATTERN_BYTES = 32;
  localparam int OFFSET_BITS       = 40;

  // Pattern register bank
  localparam int PAT_REGS   = 4;
  localparam int PAT_REG_W  = 64;
  localparam int REG_BYTES  = PAT_REGS * PAT_REG_W / 8;
  localparam int RB_IDX_W   = $clog2(REG_BYTES);
  localparam int PR_IDX_W   = $clog2(PAT_REGS);

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int CLEN_W     = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int HITS_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW      = 3'd0,
    REG_PAT_MID_LOW  = 3'd1,
    REG_PAT_MID_HIGH = 3'd2,
    REG_PAT_HIGH     = 3'd3,
    REG_PAT_LEN      = 3'd4,
    REG_MAX_HITS     = 3'd5
  } cfg_reg_e;

  // Per-cell pattern slot: expected byte and whether the cell takes part
  typedef struct packed {
    logic              used;
    logic [BYTE_W-1:0] pat;
  } cell_pat_t;

  // Match control settings
  typedef struct packed {
    logic [CLEN_W-1:0] len;
    logic [HITS_W-1:0] max_hits;
  } match_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/bpmo_cell.sv =====
// One window cell: holds a file byte, shifts it on, and compares it to its pattern slot.
`default_nettype none
module bpmo_cell (
  input  wire logic                      clk_i,
  input  wire logic                      shift_i,
  input  wire logic [bpmo_pkg::BYTE_W-1:0] byte_i,
  input  wire bpmo_pkg::cell_pat_t       pat_i,
  output logic      [bpmo_pkg::BYTE_W-1:0] byte_o,
  output logic                           match_o
);
  import bpmo_pkg::*;

  logic [BYTE_W-1:0] byte_q, byte_d;
  cell_pat_t         pat_q;

  // Take the neighbor's byte on each accepted request
  always_comb begin
    byte_d = shift_i ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    pat_q  <= pat_i;
  end

  // Unused cells always agree
  assign byte_o  = byte_q;
  assign match_o = !pat_q.used || (byte_q == pat_q.pat);

endmodule
`default_nettype wire

// ===== hdl/bpmo_cfg.sv =====
// Configuration registers and alignment of the pattern onto the cell row.
`default_nettype none
module bpmo_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [bpmo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bpmo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bpmo_pkg::match_cfg_t               cfg_o,
  output bpmo_pkg::cell_pat_t                cell_pat_o [bpmo_pkg::MAX_PATTERN_BYTES]
);
  import bpmo_pkg::*;

  logic [PAT_REG_W-1:0] pat_q [PAT_REGS];
  logic [PAT_REG_W-1:0] pat_d [PAT_REGS];
  logic [LEN_W-1:0]     len_q, len_d;
  logic [HITS_W-1:0]    max_hits_q, max_hits_d;
  logic [BYTE_W-1:0]    pbytes [REG_BYTES];
  logic [CLEN_W-1:0]    len_c;

  // Decode a register write
  always_comb begin
    pat_d      = pat_q;
    len_d      = len_q;
    max_hits_d = max_hits_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH: begin
          pat_d[cfg_index_i[PR_IDX_W-1:0]] = cfg_data_i[PAT_REG_W-1:0];
        end
        REG_PAT_LEN: begin
          len_d = cfg_data_i[LEN_W-1:0];
        end
        REG_MAX_HITS: begin
          max_hits_d = cfg_data_i[HITS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < PAT_REGS; r++) begin
        pat_q[r] <= '0;
      end
      len_q      <= '0;
      max_hits_q <= '0;
    end else begin
      pat_q      <= pat_d;
      len_q      <= len_d;
      max_hits_q <= max_hits_d;
    end
  end

  // Split the register bank into pattern bytes
  always_comb begin
    for (int j = 0; j < REG_BYTES; j++) begin
      pbytes[j] = pat_q[j / 8][(j % 8) * 8 +: 8];
    end
  end

  // Clamp the length to the row size
  always_comb begin
    if (32'(len_q) > MAX_PATTERN_BYTES) begin
      len_c = CLEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_c = CLEN_W'(len_q);
    end
  end

  // Cell i holds the byte seen i requests ago: it checks pattern byte len-1-i
  always_comb begin
    logic [CLEN_W-1:0] idx;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      idx = len_c - CLEN_W'(1) - CLEN_W'(i);
      cell_pat_o[i].used = (32'(len_c) > i);
      if ((32'(len_c) > i) && (32'(idx) < REG_BYTES)) begin
        cell_pat_o[i].pat = pbytes[idx[RB_IDX_W-1:0]];
      end else begin
        cell_pat_o[i].pat = '0;
      end
    end
  end

  assign cfg_o.len      = len_c;
  assign cfg_o.max_hits = max_hits_q;

endmodule
`default_nettype wire

// ===== hdl/byte_pattern_match_offsets.sv =====
// Top level: byte stream pattern search reporting match start offsets.
// A result passes the compare stage, then the output register, after its byte is accepted.
// One byte per cycle unless the compare stage is held; a row of 32 byte cells shifts the
// window once per byte and all cells compare in parallel in the cycle after the byte enters.
// A result waiting at the output holds the compare stage only when that stage also hits.
// Reset (rst_ni low, asynchronous) clears registers, offset, hit count and stop flag.
`default_nettype none
module byte_pattern_match_offsets (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bpmo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bpmo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // byte stream in
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  wire logic                          s_axis_tuser,  // [0] first_of_file
  // match stream out
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // [39:0] match_offset
  output logic                               m_axis_tuser   // [0] limit_reached
);
  import bpmo_pkg::*;

  match_cfg_t        cfg;
  cell_pat_t         cell_pat [MAX_PATTERN_BYTES];
  logic [BYTE_W-1:0] chain    [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_match;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic                   s_acc;
  logic                   s1_valid_q, s1_valid_d;
  logic                   s1_first_q;
  logic [OFFSET_BITS-1:0] s1_pos_q;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_eff;
  logic [HITS_W-1:0]      hits_q, hits_d, hits_eff, hits_new;
  logic                   stopped_q, stopped_d, stopped_eff;
  logic                   out_valid_q, out_valid_d;
  logic [OFFSET_BITS-1:0] out_off_q;
  logic                   out_lim_q;
  logic [OFFSET_BITS-1:0] len_m1;
  logic                   hit, lim, s1_done;

  assign cfg_ready_o = 1'b1;

  bpmo_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cell_pat_o  (cell_pat)
  );

  // Window row: cell 0 takes the new byte, each cell hands its byte to the next
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    if (i == 0) begin : g_head
      assign byte_in = s_axis_tdata;
    end else begin : g_link
      assign byte_in = chain[i-1];
    end
    bpmo_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (s_acc),
      .byte_i  (byte_in),
      .pat_i   (cell_pat[i]),
      .byte_o  (chain[i]),
      .match_o (cell_match[i])
    );
  end

  // File start restarts count and stop flag for the byte in the compare stage
  always_comb begin
    hits_eff    = s1_first_q ? '0 : hits_q;
    stopped_eff = s1_first_q ? 1'b0 : stopped_q;
    len_m1      = OFFSET_BITS'(cfg.len) - OFFSET_BITS'(1);
    hit         = s1_valid_q && (cfg.len != '0) && !stopped_eff &&
                  (s1_pos_q >= len_m1) && (&cell_match);
    hits_new    = (hits_eff == '1) ? hits_eff : hits_eff + HITS_W'(1);
    lim         = (cfg.max_hits != '0) && (hits_new >= cfg.max_hits);
  end

  // Compare stage moves on unless a hit must wait for the output register
  assign s1_done       = s1_valid_q && (!hit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_done;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Advance the file position, saturating; a first_of_file byte takes position zero
  always_comb begin
    pos_eff = s_axis_tuser ? '0 : pos_q;
    pos_d   = pos_q;
    if (s_acc) begin
      pos_d = (pos_eff == OFF_MAX) ? pos_eff : pos_eff + OFFSET_BITS'(1);
    end
  end

  // Update hit count and stop flag as a compare retires
  always_comb begin
    hits_d    = hits_q;
    stopped_d = stopped_q;
    if (s1_done) begin
      hits_d    = hit ? hits_new : hits_eff;
      stopped_d = hit ? (stopped_eff || lim) : stopped_eff;
    end
  end

  assign s1_valid_d  = s_acc || (s1_valid_q && !s1_done);
  assign out_valid_d = (s1_done && hit) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pos_q       <= '0;
      hits_q      <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pos_q       <= pos_d;
      hits_q      <= hits_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the compare and output stages
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_first_q <= s_axis_tuser;
      s1_pos_q   <= pos_eff;
    end
    if (s1_done && hit) begin
      out_off_q <= s1_pos_q - len_m1;
      out_lim_q <= lim;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_off_q;
  assign m_axis_tuser  = out_lim_q;

`ifndef ASSERT_OFF
  // A search only stops after at least one reported match
  a_stop_has_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (hits_q != '0))
    else $error("stop flag set with zero hit count");

  // Reaching the limit stops the search
  a_limit_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && hit && lim) |=> stopped_q)
    else $error("limit reached but search not stopped");

  // The limit flag only appears when a limit is configured
  a_limit_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && hit && lim) |-> (cfg.max_hits != '0))
    else $error("limit flag without a configured limit");
`endif

endmodule
`default_nettype wire
